/* src/nms_pkg.sv */
// Shared types and constants for the edge non-maximum suppression block.
package nms_pkg;

  localparam int FW_BITS       = 11;   // frame_width register
  localparam int HEIGHT_BITS   = 13;   // frame_height register
  localparam int ROW_BITS      = 12;   // row position, 0..4095
  localparam int CFG_DATA_BITS = 13;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QCOUNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  localparam logic [FW_BITS-1:0]     WIDTH_RESET  = 11'd640;
  localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 13'd480;
  localparam logic [HEIGHT_BITS-1:0] HEIGHT_MIN   = 13'd2;
  localparam logic [HEIGHT_BITS-1:0] HEIGHT_MAX   = 13'd4096;

  typedef enum logic [1:0] {
    DIR_0   = 2'd0,
    DIR_45  = 2'd1,
    DIR_90  = 2'd2,
    DIR_135 = 2'd3
  } dir_t;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_index_t;

  typedef enum logic {
    MODE_PIXEL = 1'b0,
    MODE_DRAIN = 1'b1
  } mode_t;

  // per-request control carried from front to back
  typedef struct packed {
    logic emit;
    logic last;
    logic top;
    logic bottom;
    logic left;
    logic right;
  } nms_ctl_t;

endpackage

/* src/nms_fifo.sv */
// Small register queue between the front and back parts.
module nms_fifo
  import nms_pkg::*;
#(
  parameter int WIDTH = 56,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           push_data,
  input  logic                       pop,
  output logic                       pop_valid,
  output logic [WIDTH-1:0]           pop_data,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = $clog2(DEPTH);
  localparam int CB = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;

  assign pop_valid = (count != '0);
  assign pop_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + CB'(1);
        2'b01:   count <= count - CB'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

/* src/nms_front.sv */
// Front part: accepts requests, tracks frame position, runs the two line buffers.
module nms_front
  import nms_pkg::*;
#(
  parameter int MAX_WIDTH = 1024,
  parameter int MAG_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          restart,
  input  logic [$clog2(MAX_WIDTH+1)-1:0] width,
  input  logic [HEIGHT_BITS-1:0]        height,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          mode,
  input  logic [MAG_BITS-1:0]           magnitude,
  input  logic [1:0]                    direction,
  input  logic [QCOUNT_BITS-1:0]        queue_count,
  output logic                          q_valid,
  output nms_ctl_t                      q_ctl,
  output logic [MAG_BITS-1:0]           q_cur,
  output logic [MAG_BITS-1:0]           q_l1_mag,
  output logic [1:0]                    q_l1_dir,
  output logic [MAG_BITS-1:0]           q_l2_mag
);

  localparam int WB = $clog2(MAX_WIDTH + 1);
  localparam int AW = $clog2(MAX_WIDTH);
  localparam int PB = $clog2(MAX_WIDTH + 2);

  logic [ROW_BITS-1:0] in_row;
  logic [WB-1:0]       in_col;
  logic [PB-1:0]       pending;
  logic [AW-1:0]       wptr;

  logic                s1_valid;
  nms_ctl_t            s1_ctl;
  logic [MAG_BITS-1:0] s1_cur;
  logic [AW-1:0]       s1_addr;

  logic [MAG_BITS+1:0] line1 [MAX_WIDTH];
  logic [MAG_BITS-1:0] line2 [MAX_WIDTH];
  logic [MAG_BITS+1:0] rd1;
  logic [MAG_BITS-1:0] rd2;

  logic                accept;
  logic                is_pixel;
  logic                push;
  logic [WB-1:0]       w_m1;
  logic [ROW_BITS-1:0] h_m1;
  logic                row_last;
  logic                col_last;
  logic [ROW_BITS-1:0] cr;
  logic [WB-1:0]       cc;
  nms_ctl_t            ctl;
  logic [MAG_BITS-1:0] cur;
  logic [1:0]          wr_dir;

  assign in_ready = !rst &&
    (({1'b0, queue_count} + (QCOUNT_BITS+1)'(s1_valid)) < (QCOUNT_BITS+1)'(QUEUE_DEPTH));
  assign accept   = in_valid && in_ready;
  assign is_pixel = (mode == MODE_PIXEL);
  // a pixel while a drain is owed, or a drain with nothing owed, is dropped
  assign push     = accept && (is_pixel ? (pending == '0) : (pending != '0));

  assign w_m1     = width - WB'(1);
  assign h_m1     = ROW_BITS'(height - HEIGHT_BITS'(1));
  assign row_last = (in_row >= h_m1);
  assign col_last = (in_col >= w_m1);
  assign cur      = is_pixel ? magnitude : '0;
  assign wr_dir   = is_pixel ? direction : 2'b00;

  // position of the pixel judged by this request
  always_comb begin
    if (is_pixel) begin
      if (in_col != '0) begin
        cr = in_row - ROW_BITS'(1);
        cc = in_col - WB'(1);
      end else begin
        cr = in_row - ROW_BITS'(2);
        cc = w_m1;
      end
    end else if (pending > PB'(width)) begin
      cr = h_m1 - ROW_BITS'(1);
      cc = w_m1;
    end else begin
      cr = h_m1;
      cc = width - WB'(pending);
    end
    ctl.emit   = is_pixel ? ((in_row >= ROW_BITS'(2)) ||
                             (in_row == ROW_BITS'(1) && in_col != '0)) : 1'b1;
    ctl.last   = !is_pixel && (pending == PB'(1));
    ctl.top    = (cr == '0);
    ctl.bottom = (cr == h_m1);
    ctl.left   = (cc == '0);
    ctl.right  = (cc == w_m1);
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      in_row  <= '0;
      in_col  <= '0;
      pending <= '0;
      wptr    <= '0;
    end else if (push) begin
      wptr <= (wptr == AW'(w_m1)) ? '0 : wptr + 1'b1;
      if (is_pixel) begin
        if (row_last && col_last) begin
          in_row  <= '0;
          in_col  <= '0;
          pending <= PB'(width) + PB'(1);
        end else if (col_last) begin
          in_col <= '0;
          in_row <= in_row + ROW_BITS'(1);
        end else begin
          in_col <= in_col + WB'(1);
        end
      end else begin
        pending <= pending - PB'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      s1_ctl  <= ctl;
      s1_cur  <= cur;
      s1_addr <= wptr;
    end
  end

  // line 1: value from one row back; read before write at the same address
  always_ff @(posedge clk) begin
    if (push) begin
      line1[wptr] <= {wr_dir, cur};
      rd1         <= line1[wptr];
    end
  end

  // line 2 is fed from line 1's output in the following cycle
  always_ff @(posedge clk) begin
    if (s1_valid) begin
      line2[s1_addr] <= rd1[MAG_BITS-1:0];
    end
    if (push) begin
      rd2 <= line2[wptr];
    end
  end

  assign q_valid  = s1_valid;
  assign q_ctl    = s1_ctl;
  assign q_cur    = s1_cur;
  assign q_l1_mag = rd1[MAG_BITS-1:0];
  assign q_l1_dir = rd1[MAG_BITS+1:MAG_BITS];
  assign q_l2_mag = rd2;

endmodule

/* src/nms_back.sv */
// Back part: 3x3 window registers, the suppression compare and the output register.
module nms_back
  import nms_pkg::*;
#(
  parameter int MAG_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                head_valid,
  input  nms_ctl_t            head_ctl,
  input  logic [MAG_BITS-1:0] head_cur,
  input  logic [MAG_BITS-1:0] head_l1_mag,
  input  logic [1:0]          head_l1_dir,
  input  logic [MAG_BITS-1:0] head_l2_mag,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [MAG_BITS-1:0] kept_magnitude,
  output logic                frame_last
);

  // rN_k: row N back, k pixels back
  logic [MAG_BITS-1:0] r0_1, r0_2, r1_1, r1_2, r2_1, r2_2;
  dir_t                cdir;

  logic [MAG_BITS-1:0] nb_a, nb_b;
  logic                a_ok, b_ok;
  logic [MAG_BITS-1:0] kept;

  assign pop = head_valid && (!out_valid || out_ready);

  always_comb begin
    nb_a = r1_2;
    nb_b = head_l1_mag;
    a_ok = !head_ctl.left;
    b_ok = !head_ctl.right;
    unique case (cdir)
      DIR_0: begin
        nb_a = r1_2;
        nb_b = head_l1_mag;
        a_ok = !head_ctl.left;
        b_ok = !head_ctl.right;
      end
      DIR_45: begin
        nb_a = r2_2;
        nb_b = head_cur;
        a_ok = !head_ctl.top && !head_ctl.left;
        b_ok = !head_ctl.bottom && !head_ctl.right;
      end
      DIR_90: begin
        nb_a = r2_1;
        nb_b = r0_1;
        a_ok = !head_ctl.top;
        b_ok = !head_ctl.bottom;
      end
      DIR_135: begin
        nb_a = head_l2_mag;
        nb_b = r0_2;
        a_ok = !head_ctl.top && !head_ctl.right;
        b_ok = !head_ctl.bottom && !head_ctl.left;
      end
      default: begin
        a_ok = 1'b0;
        b_ok = 1'b0;
      end
    endcase
    if ((r1_1 == '0) || (a_ok && r1_1 <= nb_a) || (b_ok && r1_1 <= nb_b)) begin
      kept = '0;
    end else begin
      kept = r1_1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      r0_2 <= r0_1;
      r0_1 <= head_cur;
      r1_2 <= r1_1;
      r1_1 <= head_l1_mag;
      cdir <= dir_t'(head_l1_dir);
      r2_2 <= r2_1;
      r2_1 <= head_l2_mag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && head_ctl.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head_ctl.emit) begin
      kept_magnitude <= kept;
      frame_last     <= head_ctl.last;
    end
  end

endmodule

/* src/edge_nonmax_suppression.sv */
// Top level of the streaming 3x3 non-maximum suppression block.
// Takes one request per clock while the queue has room, with the output able to stall on its own:
// a small queue sits between the line-buffer front and the compare back. A result is
// registered in the front stage, then the queue, then the output register once the
// request that completes its 3x3 window is accepted; in stream terms that is
// one row and one pixel behind the input. Drain requests push out the last width+1
// results of a frame, the final one flagged by frame_last.
// Line buffers are two memories of MAX_WIDTH words: the first is read and written at
// one address per cycle, the second is read at one address and written at another in
// the same cycle. Their contents are only read for pixels already written in the
// current frame, so no clearing is done.
// Any register write restarts the stream position and drops owed results.
module edge_nonmax_suppression
  import nms_pkg::*;
#(
  parameter int MAX_WIDTH = 1024,
  parameter int MAG_BITS  = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     write_enable,
  input  logic                     write_index,
  input  logic [CFG_DATA_BITS-1:0] write_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     mode,
  input  logic [MAG_BITS-1:0]      magnitude,
  input  logic [1:0]               direction,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [MAG_BITS-1:0]      kept_magnitude,
  output logic                     frame_last
);

  localparam int WB = $clog2(MAX_WIDTH + 1);
  localparam int CW = (WB > FW_BITS) ? WB : FW_BITS;
  localparam int EW = $bits(nms_ctl_t) + 3 * MAG_BITS + 2;

  logic [FW_BITS-1:0]     frame_width;
  logic [HEIGHT_BITS-1:0] frame_height;
  logic [CW-1:0]          fw_ext;
  logic [WB-1:0]          width;
  logic [HEIGHT_BITS-1:0] height;

  nms_ctl_t               f_ctl, b_ctl;
  logic                   f_valid;
  logic [MAG_BITS-1:0]    f_cur, f_l1_mag, f_l2_mag;
  logic [1:0]             f_l1_dir;
  logic [MAG_BITS-1:0]    b_cur, b_l1_mag, b_l2_mag;
  logic [1:0]             b_l1_dir;
  logic [EW-1:0]          q_in, q_out;
  logic                   q_head_valid;
  logic                   q_pop;
  logic [QCOUNT_BITS-1:0] q_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
    end else if (write_enable) begin
      case (reg_index_t'(write_index))
        REG_FRAME_WIDTH:  frame_width  <= write_data[FW_BITS-1:0];
        REG_FRAME_HEIGHT: frame_height <= write_data;
        default:          frame_width  <= frame_width;
      endcase
    end
  end

  // clamp geometry to the supported range
  assign fw_ext = CW'(frame_width);
  assign width  = (fw_ext < CW'(2)) ? WB'(2) :
                  (fw_ext > CW'(MAX_WIDTH)) ? WB'(MAX_WIDTH) : WB'(fw_ext);
  assign height = (frame_height < HEIGHT_MIN) ? HEIGHT_MIN :
                  (frame_height > HEIGHT_MAX) ? HEIGHT_MAX : frame_height;

  nms_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAG_BITS  (MAG_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .restart     (write_enable),
    .width       (width),
    .height      (height),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .mode        (mode),
    .magnitude   (magnitude),
    .direction   (direction),
    .queue_count (q_count),
    .q_valid     (f_valid),
    .q_ctl       (f_ctl),
    .q_cur       (f_cur),
    .q_l1_mag    (f_l1_mag),
    .q_l1_dir    (f_l1_dir),
    .q_l2_mag    (f_l2_mag)
  );

  assign q_in = {f_ctl, f_cur, f_l1_dir, f_l1_mag, f_l2_mag};

  nms_fifo #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (f_valid),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_valid (q_head_valid),
    .pop_data  (q_out),
    .count     (q_count)
  );

  assign {b_ctl, b_cur, b_l1_dir, b_l1_mag, b_l2_mag} = q_out;

  nms_back #(
    .MAG_BITS (MAG_BITS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .head_valid     (q_head_valid),
    .head_ctl       (b_ctl),
    .head_cur       (b_cur),
    .head_l1_mag    (b_l1_mag),
    .head_l1_dir    (b_l1_dir),
    .head_l2_mag    (b_l2_mag),
    .pop            (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .kept_magnitude (kept_magnitude),
    .frame_last     (frame_last)
  );

endmodule

/* test/edge_nonmax_suppression_test.sv */
// Self-checking testbench for the streaming 3x3 non-maximum suppression block.
`timescale 1ns / 100ps

import nms_pkg::*;

localparam int NMS_MAX_WIDTH  = 1024;
localparam int NMS_MAX_HEIGHT = 4096;
localparam int NMS_MAG_RING   = 2 * NMS_MAX_WIDTH + 2;
localparam int NMS_DIR_RING   = NMS_MAX_WIDTH + 1;

typedef struct packed {
  logic [15:0] kept;
  logic        last;
} kept_pixel_t;

class suppression_scoreboard;
  logic [FW_BITS-1:0]     width_reg;
  logic [HEIGHT_BITS-1:0] height_reg;
  logic [15:0]            mag_ring [NMS_MAG_RING];
  dir_t                   dir_ring [NMS_DIR_RING];
  int                     mag_wp;
  int                     dir_wp;
  int                     row;
  int                     col;
  int                     owed;
  int                     errors;
  kept_pixel_t            pending_pixels [$];

  function new();
    width_reg  = WIDTH_RESET;
    height_reg = HEIGHT_RESET;
    foreach (mag_ring[i]) mag_ring[i] = '0;
    foreach (dir_ring[i]) dir_ring[i] = DIR_0;
    mag_wp = 0;
    dir_wp = 0;
    row    = 0;
    col    = 0;
    owed   = 0;
    errors = 0;
  endfunction

  function int eff_width();
    if (width_reg < 2) return 2;
    if (width_reg > NMS_MAX_WIDTH) return NMS_MAX_WIDTH;
    return int'(width_reg);
  endfunction

  function int eff_height();
    if (height_reg < HEIGHT_MIN) return 2;
    if (height_reg > HEIGHT_MAX) return NMS_MAX_HEIGHT;
    return int'(height_reg);
  endfunction

  function int outstanding();
    return pending_pixels.size();
  endfunction

  function void queue_result(kept_pixel_t res);
    pending_pixels = {pending_pixels, res};
  endfunction

  // any write restarts the stream and drops owed drain results
  function void write_reg(reg_index_t idx, logic [CFG_DATA_BITS-1:0] val);
    if (idx == REG_FRAME_WIDTH) width_reg = val[FW_BITS-1:0];
    else height_reg = val;
    row  = 0;
    col  = 0;
    owed = 0;
  endfunction

  // magnitude k positions behind the current one; k == 0 is the current pixel
  function logic [15:0] mag_back(int k, logic [15:0] cur);
    if (k == 0) return cur;
    return mag_ring[(mag_wp + NMS_MAG_RING - (k % NMS_MAG_RING)) % NMS_MAG_RING];
  endfunction

  function dir_t dir_back(int k);
    return dir_ring[(dir_wp + NMS_DIR_RING - (k % NMS_DIR_RING)) % NMS_DIR_RING];
  endfunction

  function void push_line(logic [15:0] mag, dir_t d);
    mag_ring[mag_wp] = mag;
    dir_ring[dir_wp] = d;
    mag_wp = (mag_wp + 1) % NMS_MAG_RING;
    dir_wp = (dir_wp + 1) % NMS_DIR_RING;
  endfunction

  // center (cr,cc) sits width+1 positions behind the current position
  function logic [15:0] suppress_center(int cr, int cc, logic [15:0] cur);
    int w;
    int h;
    int k;
    int nr;
    int nc;
    int ndr [2];
    int ndc [2];
    logic [15:0] m;
    w = eff_width();
    h = eff_height();
    m = mag_back(w + 1, cur);
    if (m == 16'd0) return 16'd0;
    case (dir_back(w + 1))
      DIR_0: begin
        ndr = '{0, 0};
        ndc = '{-1, 1};
      end
      DIR_45: begin
        ndr = '{-1, 1};
        ndc = '{-1, 1};
      end
      DIR_90: begin
        ndr = '{-1, 1};
        ndc = '{0, 0};
      end
      default: begin
        ndr = '{-1, 1};
        ndc = '{1, -1};
      end
    endcase
    for (k = 0; k < 2; k++) begin
      nr = cr + ndr[k];
      nc = cc + ndc[k];
      if (nr >= 0 && nr < h && nc >= 0 && nc < w &&
          m <= mag_back(w + 1 - ndr[k] * w - ndc[k], cur))
        return 16'd0;
    end
    return m;
  endfunction

  function void note_request(mode_t m, logic [15:0] mag, dir_t d);
    int w;
    int h;
    int cr;
    int cc;
    kept_pixel_t res;
    w = eff_width();
    h = eff_height();
    if (m == MODE_PIXEL) begin
      if (owed != 0) return;
      if (row >= 2 || (row == 1 && col >= 1)) begin
        cr = (col >= 1) ? row - 1 : row - 2;
        cc = (col >= 1) ? col - 1 : w - 1;
        res.kept = suppress_center(cr, cc, mag);
        res.last = 1'b0;
        queue_result(res);
      end
      push_line(mag, d);
      if (row >= h - 1 && col >= w - 1) begin
        row  = 0;
        col  = 0;
        owed = w + 1;
      end else if (col >= w - 1) begin
        col = 0;
        row++;
      end else begin
        col++;
      end
    end else if (owed != 0) begin
      if (owed > w) begin
        cr = h - 2;
        cc = w - 1;
      end else begin
        cr = h - 1;
        cc = w - owed;
      end
      res.kept = suppress_center(cr, cc, 16'd0);
      res.last = (owed == 1);
      queue_result(res);
      push_line(16'd0, DIR_0);
      owed--;
    end
  endfunction

  function void check_result(logic [15:0] kept, logic last);
    kept_pixel_t exp_px;
    if (pending_pixels.size() == 0) begin
      $error("unexpected result: kept_magnitude %0d frame_last %0b", kept, last);
      errors++;
      return;
    end
    exp_px = pending_pixels.pop_front();
    if (kept !== exp_px.kept) begin
      $error("kept_magnitude: expected %0d, got %0d", exp_px.kept, kept);
      errors++;
    end
    if (last !== exp_px.last) begin
      $error("frame_last: expected %0b, got %0b", exp_px.last, last);
      errors++;
    end
  endfunction
endclass

module edge_nonmax_suppression_test;
  localparam int RANDOM_ITEMS  = 480;
  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT   = 1000000;

  logic                     clk;
  logic                     rst;
  logic                     write_enable;
  logic                     write_index;
  logic [CFG_DATA_BITS-1:0] write_data;
  logic                     in_valid;
  logic                     in_ready;
  logic                     mode;
  logic [15:0]              magnitude;
  logic [1:0]               direction;
  logic                     out_valid;
  logic                     out_ready;
  logic [15:0]              kept_magnitude;
  logic                     frame_last;

  bit                       no_idle;
  int                       items_sent;
  int                       cycles;
  suppression_scoreboard    sb = new();

  // 3x3 opening frame: extremes, ties and every direction
  logic [15:0] tiny_mag [9] = '{16'd5, 16'hFFFF, 16'd5, 16'd7, 16'd7, 16'd0,
                                16'd1, 16'hFFFF, 16'd3};
  dir_t        tiny_dir [9] = '{DIR_0, DIR_90, DIR_45, DIR_135, DIR_0, DIR_90,
                                DIR_45, DIR_135, DIR_0};

  edge_nonmax_suppression u_top (
    .clk            (clk),
    .rst            (rst),
    .write_enable   (write_enable),
    .write_index    (write_index),
    .write_data     (write_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .mode           (mode),
    .magnitude      (magnitude),
    .direction      (direction),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .kept_magnitude (kept_magnitude),
    .frame_last     (frame_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // small values often, so ties and zeros are common
  function automatic logic [15:0] rand_mag();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return 16'd0;
    if (r < 60) return 16'($urandom_range(1, 6));
    if (r < 75) return 16'($urandom_range(0, 255));
    if (r < 92) return 16'($urandom);
    return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'hFFFE;
  endfunction

  function automatic dir_t rand_dir();
    return dir_t'($urandom_range(0, 3));
  endfunction

  task automatic send_item(input mode_t m, input logic [15:0] mg, input dir_t d);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    mode      <= m;
    magnitude <= mg;
    direction <= d;
    do @(posedge clk); while (!in_ready);
    sb.note_request(m, mg, d);
  endtask

  task automatic send_pixels(input int count);
    repeat (count) send_item(MODE_PIXEL, rand_mag(), rand_dir());
  endtask

  // wait out every owed result plus the pipeline, so the block is idle
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_regs(input bit do_w, input logic [CFG_DATA_BITS-1:0] wv,
                          input bit do_h, input logic [CFG_DATA_BITS-1:0] hv);
    if (do_w) begin
      write_enable <= 1'b1;
      write_index  <= REG_FRAME_WIDTH;
      write_data   <= wv;
      @(posedge clk);
      sb.write_reg(REG_FRAME_WIDTH, wv);
    end
    if (do_h) begin
      write_enable <= 1'b1;
      write_index  <= REG_FRAME_HEIGHT;
      write_data   <= hv;
      @(posedge clk);
      sb.write_reg(REG_FRAME_HEIGHT, hv);
    end
    write_enable <= 1'b0;
  endtask

  task automatic random_config();
    logic [CFG_DATA_BITS-1:0] wv;
    logic [CFG_DATA_BITS-1:0] hv;
    int r;
    int which;
    r = $urandom_range(0, 99);
    if (r < 70) wv = 13'($urandom_range(2, 8));
    else if (r < 85) wv = 13'($urandom_range(9, 40));
    else if (r < 93) wv = 13'($urandom_range(0, 1));
    else wv = 13'($urandom_range(41, 100));
    // bits above the width register are dropped
    if ($urandom_range(0, 9) == 0) wv[12:11] = 2'($urandom_range(1, 3));
    r = $urandom_range(0, 99);
    if (r < 75) hv = 13'($urandom_range(2, 6));
    else if (r < 88) hv = 13'($urandom_range(0, 1));
    else hv = 13'($urandom_range(7, 20));
    which = $urandom_range(0, 2);
    set_regs(which != 1, wv, which != 0, hv);
  endtask

  task automatic run_frame(input bit noisy);
    int w;
    int h;
    int n;
    int abort_at;
    int drains;
    w = sb.eff_width();
    h = sb.eff_height();
    abort_at = (noisy && $urandom_range(0, 99) < 6) ? $urandom_range(0, w * h - 1) : -1;
    for (n = 0; n < w * h; n++) begin
      // a random frame also stops early once the item budget is spent
      if (n == abort_at || (noisy && items_sent >= RANDOM_ITEMS)) begin
        // broken frame: stop mid-stream and restart through a write
        settle();
        random_config();
        return;
      end
      if (noisy && $urandom_range(0, 99) < 3)
        send_item(MODE_DRAIN, rand_mag(), rand_dir());
      if (noisy && $urandom_range(0, 99) < 2)
        settle();
      send_item(MODE_PIXEL, rand_mag(), rand_dir());
      items_sent++;
    end
    // pixels are ignored while drain results are owed
    if (noisy && $urandom_range(0, 99) < 30)
      repeat ($urandom_range(1, 2)) send_item(MODE_PIXEL, rand_mag(), rand_dir());
    drains = (noisy && $urandom_range(0, 99) < 6) ? $urandom_range(0, w) : w + 1;
    repeat (drains) begin
      send_item(MODE_DRAIN, rand_mag(), rand_dir());
      items_sent++;
    end
    if (drains < w + 1) begin
      settle();
      random_config();
    end
    if (noisy && $urandom_range(0, 99) < 20)
      send_item(MODE_DRAIN, rand_mag(), rand_dir());
  endtask

  initial begin : result_sink
    int hold;
    out_ready <= 1'b0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) sb.check_result(kept_magnitude, frame_last);
      if (hold > 0) begin
        hold--;
      end else if (out_ready) begin
        hold = pick_gap();
        if (hold > 0) out_ready <= 1'b0;
        else hold = $urandom_range(0, 12);
      end else begin
        out_ready <= 1'b1;
        hold = $urandom_range(0, 20);
      end
    end
  end

  initial begin : watchdog
    cycles = 0;
    while (cycles <= CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("edge_nonmax_suppression_test: FAIL");
    $finish;
  end

  initial begin : stimulus
    int n;
    rst          <= 1'b1;
    in_valid     <= 1'b0;
    mode         <= MODE_PIXEL;
    magnitude    <= '0;
    direction    <= DIR_0;
    write_enable <= 1'b0;
    write_index  <= REG_FRAME_WIDTH;
    write_data   <= '0;
    no_idle    = 1'b0;
    items_sent = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_regs(1'b1, 13'd3, 1'b1, 13'd3);
    for (n = 0; n < 9; n++) send_item(MODE_PIXEL, tiny_mag[n], tiny_dir[n]);
    send_item(MODE_PIXEL, 16'hFFFF, DIR_90);
    repeat (4) send_item(MODE_DRAIN, 16'd0, DIR_0);
    send_item(MODE_DRAIN, 16'hFFFF, DIR_135);
    settle();
    set_regs(1'b1, 13'd2, 1'b1, 13'd2);
    send_item(MODE_PIXEL, 16'hFFFF, DIR_90);
    send_item(MODE_PIXEL, 16'hFFFF, DIR_0);
    send_item(MODE_PIXEL, 16'd1, DIR_45);
    send_item(MODE_PIXEL, 16'd0, DIR_135);
    repeat (3) send_item(MODE_DRAIN, 16'hFFFF, DIR_135);

    while (items_sent < RANDOM_ITEMS) begin
      no_idle = ($urandom_range(0, 99) < 15);
      if ($urandom_range(0, 99) < 40) begin
        settle();
        random_config();
      end
      run_frame(1'b1);
    end

    // widest and tallest settings, kept short where the frame is huge
    no_idle = 1'b1;
    settle();
    set_regs(1'b1, 13'h1FFF, 1'b1, 13'h1FFF);
    send_pixels(1060);
    settle();
    set_regs(1'b1, 13'd2, 1'b1, 13'd4096);
    send_pixels(40);
    no_idle = 1'b0;
    settle();
    set_regs(1'b1, 13'd5, 1'b1, 13'd4);
    run_frame(1'b0);
    settle();

    if (sb.errors == 0) $display("edge_nonmax_suppression_test: PASS");
    else $display("edge_nonmax_suppression_test: FAIL");
    $finish;
  end
endmodule
